@@ sv/sha_pkg.sv @@
`default_nettype none
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       init;
      logic       load;
      logic       round;
      logic       add;
      logic [5:0] rnd;
      logic [2:0] out_idx;
   } core_ctl_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS = 64;
   localparam logic [5:0] LEN_START = 6'd56;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

@@ sv/sha_if.sv @@
`default_nettype none
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       message_end;
   modport source (output valid, data_byte, byte_present, message_end, input ready);
   modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        digest_last;
   modport source (output valid, digest_word, word_index, digest_last, input ready);
   modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface
`default_nettype wire

@@ sv/sha_ram.sv @@
`default_nettype none
module sha_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ sv/sha_core.sv @@
`default_nettype none
module sha_core
   import sha_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire core_ctl_type ctl,
   input  wire logic [31:0]  ram_rdata,
   output logic      [31:0]  digest_word
);

   logic [31:0] hash_ff [8];
   logic [31:0] var_ff [8];
   logic [31:0] sched_ff [16];
   logic [31:0] w_cur, s0, s1, t1, t2, e, a;

   // The schedule window holds the last sixteen words, the newest at the top.
   always_comb begin
      s0 = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      s1 = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      w_cur = (ctl.rnd < 6'(BLOCK_WORDS)) ? ram_rdata : s1 + sched_ff[9] + s0 + sched_ff[0];
      e = var_ff[4];
      a = var_ff[0];
      t1 = var_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
           ((e & var_ff[5]) ^ (~e & var_ff[6])) + K_TAB[ctl.rnd] + w_cur;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
           ((a & var_ff[1]) ^ (a & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= IV[i];
      end else if (ctl.add) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + var_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
      end else if (ctl.round) begin
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[15] <= w_cur;
      end
   end

   assign digest_word = hash_ff[ctl.out_idx];

endmodule
`default_nettype wire

@@ sv/sha256_stream_hasher.sv @@
`default_nettype none
// Channel | Dir | Word carries
// req     | in  | data_byte, byte_present, message_end
// rsp     | out | digest_word, word_index, digest_last
//
// A byte is accepted while the hasher is idle; ready is low while it is busy. The byte that
// fills a 64-byte block makes the hasher busy: it loads the working variables, runs
// one compression round per cycle fed from the block store RAM, and adds into the hash.
// The end of a message writes the padding words, runs one or two compressions,
// then eight digest words, each held until taken. Synchronous reset puts the
// standard initial hash in place at once.
module sha256_stream_hasher
   import sha_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   sha_req_if.sink   req_chan,
   sha_rsp_if.source rsp_chan
);

   state_type    state_ff, state_in;
   logic [5:0]   fill_ff, fill_in;
   logic [23:0]  pack_ff, pack_in;
   logic [63:0]  bitlen_ff, bitlen_in;
   logic         end_ff, end_in;
   logic         final_ff, final_in;
   logic         pad2_ff, pad2_in;
   logic         first_ff, first_in;
   logic         lenblk_ff, lenblk_in;
   logic [3:0]   pw_ff, pw_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [2:0]   idx_ff, idx_in;
   logic         we, lenblk_now;
   logic [3:0]   waddr;
   logic [31:0]  wdata, rdata;
   core_ctl_type ctl;
   logic         acc;

   assign acc = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         bitlen_ff <= '0;
         end_ff <= 1'b0;
         final_ff <= 1'b0;
         pad2_ff <= 1'b0;
         first_ff <= 1'b0;
         lenblk_ff <= 1'b0;
         pw_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bitlen_ff <= bitlen_in;
         end_ff <= end_in;
         final_ff <= final_in;
         pad2_ff <= pad2_in;
         first_ff <= first_in;
         lenblk_ff <= lenblk_in;
         pw_ff <= pw_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
      pack_ff <= pack_in;
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      pack_in = pack_ff;
      bitlen_in = bitlen_ff;
      end_in = end_ff;
      final_in = final_ff;
      pad2_in = pad2_ff;
      first_in = first_ff;
      lenblk_in = lenblk_ff;
      pw_in = pw_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      we = 1'b0;
      waddr = fill_ff[5:2];
      wdata = {pack_ff, req_chan.data_byte};
      lenblk_now = first_ff ? (fill_ff < LEN_START) : lenblk_ff;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      ctl = '{init: 1'b0, load: 1'b0, round: 1'b0, add: 1'b0,
              rnd: cnt_ff[5:0] - 6'd1, out_idx: idx_ff};
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (acc) begin
               if (req_chan.byte_present) begin
                  we = (fill_ff[1:0] == 2'd3);
                  pack_in = {pack_ff[15:0], req_chan.data_byte};
                  fill_in = fill_ff + 6'd1;
                  bitlen_in = bitlen_ff + 64'd8;
               end
               if (req_chan.byte_present && fill_ff == 6'd63) begin
                  state_in = ST_COMP;
                  cnt_in = '0;
                  end_in = req_chan.message_end;
               end else if (req_chan.message_end) begin
                  state_in = ST_PAD;
                  first_in = 1'b1;
               end
            end
         end
         ST_PAD: begin
            we = 1'b1;
            waddr = first_ff ? fill_ff[5:2] : pw_ff;
            if (first_ff) begin
               unique case (fill_ff[1:0])
                  2'd0: wdata = {PAD_BYTE, 24'd0};
                  2'd1: wdata = {pack_ff[7:0], PAD_BYTE, 16'd0};
                  2'd2: wdata = {pack_ff[15:0], PAD_BYTE, 8'd0};
                  default: wdata = {pack_ff, PAD_BYTE};
               endcase
            end else if (lenblk_ff && pw_ff == 4'd14) begin
               wdata = bitlen_ff[63:32];
            end else if (lenblk_ff && pw_ff == 4'd15) begin
               wdata = bitlen_ff[31:0];
            end else begin
               wdata = '0;
            end
            first_in = 1'b0;
            lenblk_in = lenblk_now;
            pw_in = waddr + 4'd1;
            if (waddr == 4'(BLOCK_WORDS - 1)) begin
               state_in = ST_COMP;
               cnt_in = '0;
               final_in = lenblk_now;
               pad2_in = !lenblk_now;
            end
         end
         ST_COMP: begin
            ctl.load = (cnt_ff == 7'd0);
            ctl.round = (cnt_ff != 7'd0);
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(ROUNDS)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ctl.add = 1'b1;
            priority if (final_ff) begin
               state_in = ST_OUT;
               idx_in = '0;
            end else if (end_ff) begin
               state_in = ST_PAD;
               end_in = 1'b0;
               first_in = 1'b1;
            end else if (pad2_ff) begin
               state_in = ST_PAD;
               pad2_in = 1'b0;
               first_in = 1'b0;
               lenblk_in = 1'b1;
               pw_in = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  ctl.init = 1'b1;
                  state_in = ST_IDLE;
                  fill_in = '0;
                  bitlen_in = '0;
                  final_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   sha_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_block (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (cnt_ff[3:0]),
      .rdata (rdata)
   );

   sha_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .ram_rdata   (rdata),
      .digest_word (rsp_chan.digest_word)
   );

   assign rsp_chan.word_index = idx_ff;
   assign rsp_chan.digest_last = (idx_ff == 3'd7);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input taken while digest words are pending");

   // The counter steps once past the last round as the add cycle begins.
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 7'(ROUNDS + 1))
      else $error("round counter overran");

   a_digest_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.digest_last |=>
      !rsp_chan.valid && fill_ff == 6'd0 && bitlen_ff == 64'd0)
      else $error("message state not cleared after digest");

endmodule
`default_nettype wire
